/* sv/hlu_pkg.sv */
package hlu_pkg;

	localparam int LENGTH_BITS_DEFAULT = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef struct packed {
		logic       operation;
		logic [7:0] in_byte;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [15:0] line_length;
		logic        at_stream_end;
		logic        last;
	} out_word_t;

	// one queue entry holds every result word of one input word
	typedef struct packed {
		logic      two;
		out_word_t res0;
		out_word_t res1;
	} entry_t;

	function automatic out_word_t mk_data(input logic [7:0] b);
		out_word_t w;
		w = '0;
		w.kind = KIND_DATA;
		w.out_byte = b;
		return w;
	endfunction

	function automatic out_word_t mk_line(input logic [15:0] len, input logic eos);
		out_word_t w;
		w = '0;
		w.kind = KIND_LINE;
		w.line_length = len;
		w.at_stream_end = eos;
		return w;
	endfunction

endpackage

/* sv/hlu_front.sv */
module hlu_front #(
	parameter int LENGTH_BITS = hlu_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hlu_pkg::in_word_t item,
	input  logic              q_full,
	input  logic              cfg_valid,
	input  logic              cfg_data,
	output logic              enq,
	output hlu_pkg::entry_t   enq_entry
);
	import hlu_pkg::*;

	localparam int LW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	logic                   unfold_q;
	logic                   cr_q;
	logic                   fold_q;
	logic [LENGTH_BITS-1:0] count_q;

	logic                   take;
	logic                   cr_d;
	logic                   fold_d;
	logic [LENGTH_BITS-1:0] count_d;
	logic [1:0]             n;
	out_word_t              res [2];

	function automatic logic [15:0] sat16(input logic [LENGTH_BITS-1:0] c);
		logic [LW-1:0] e;
		e = LW'(c);
		return (e > LW'(17'h0FFFF)) ? 16'hFFFF : e[15:0];
	endfunction

	function automatic logic [LENGTH_BITS-1:0] inc(input logic [LENGTH_BITS-1:0] c);
		return (c == LEN_MAX) ? c : c + 1'b1;
	endfunction

	assign take = push & ~q_full;

	always_comb begin
		cr_d = cr_q;
		fold_d = fold_q;
		count_d = count_q;
		n = 2'd0;
		res[0] = '0;
		res[1] = '0;
		if (item.operation == OP_EOS) begin
			if (cr_q) begin
				res[n[0]] = mk_data(CH_CR);
				n = n + 2'd1;
				count_d = inc(count_d);
			end
			res[n[0]] = mk_line(sat16(count_d), 1'b1);
			n = n + 2'd1;
			count_d = '0;
			fold_d = 1'b0;
			cr_d = 1'b0;
		end else if (item.in_byte == CH_NUL) begin
			res[0] = '0;
			res[0].kind = KIND_ABORT;
			n = 2'd1;
			cr_d = 1'b0;
			fold_d = 1'b0;
			count_d = '0;
		end else begin
			if (fold_d) begin
				if (item.in_byte == CH_SP || item.in_byte == CH_TAB) begin
					fold_d = 1'b0;
				end else begin
					res[n[0]] = mk_line(sat16(count_d), 1'b0);
					n = n + 2'd1;
					count_d = '0;
					fold_d = 1'b0;
					cr_d = 1'b0;
				end
			end
			if (item.in_byte == CH_LF) begin
				cr_d = 1'b0;
				if (count_d != '0 && unfold_q) begin
					fold_d = 1'b1;
				end else begin
					res[n[0]] = mk_line(sat16(count_d), 1'b0);
					n = n + 2'd1;
					count_d = '0;
					fold_d = 1'b0;
				end
			end else begin
				if (cr_d) begin
					res[n[0]] = mk_data(CH_CR);
					n = n + 2'd1;
					count_d = inc(count_d);
				end
				if (item.in_byte == CH_CR) begin
					cr_d = 1'b1;
				end else begin
					cr_d = 1'b0;
					res[n[0]] = mk_data(item.in_byte);
					n = n + 2'd1;
					count_d = inc(count_d);
				end
			end
		end
		if (n == 2'd2) begin
			res[1].last = 1'b1;
		end else begin
			res[0].last = 1'b1;
		end
	end

	assign enq = take & (n != 2'd0);
	assign enq_entry.two = (n == 2'd2);
	assign enq_entry.res0 = res[0];
	assign enq_entry.res1 = res[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unfold_q <= 1'b0;
			cr_q <= 1'b0;
			fold_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (cfg_valid) begin
				unfold_q <= cfg_data;
			end
			if (take) begin
				cr_q <= cr_d;
				fold_q <= fold_d;
				count_q <= count_d;
			end
		end
	end

endmodule

/* sv/hlu_queue.sv */
module hlu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            enq,
	input  hlu_pkg::entry_t enq_entry,
	input  logic            deq,
	output logic            full,
	output logic            nonempty,
	output hlu_pkg::entry_t head
);
	import hlu_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_enq;
	logic             do_deq;

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head = mem_q[rd_q];
	assign do_enq = enq & ~full;
	assign do_deq = deq & nonempty;

	always_ff @(posedge clk) begin
		if (do_enq) begin
			mem_q[wr_q] <= enq_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_enq) begin
				wr_q <= nxt(wr_q);
			end
			if (do_deq) begin
				rd_q <= nxt(rd_q);
			end
			if (do_enq && !do_deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_enq && do_deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/hlu_back.sv */
module hlu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  hlu_pkg::entry_t    head,
	input  logic               nonempty,
	input  logic               pop,
	output logic               deq,
	output logic               empty,
	output hlu_pkg::out_word_t result
);
	import hlu_pkg::*;

	logic phase_q;
	logic take;

	assign empty = ~nonempty;
	assign result = phase_q ? head.res1 : head.res0;
	assign take = pop & nonempty;
	// retire the entry after its last word
	assign deq = take & (phase_q | ~head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (take) begin
			phase_q <= ~phase_q & head.two;
		end
	end

endmodule

/* sv/header_line_unfolder.sv */
// channel   direction  handshake               payload
// item      in         push / full             operation, in_byte
// result    out        empty / pop             kind, out_byte, line_length, at_stream_end, last
// cfg       in         cfg_valid / cfg_ready   unfold_enable (cfg_data)
//
// one input word per cycle while full is low; its result words are queued in the same cycle and
// the first reaches the result port from the queue entry register once earlier entries have drained
// the back end drains one result word per cycle while pop is high, so a word that yields two results
// holds a queue entry for two pops; full rises only when both entries are taken
// reset clears the line state, the unfold flag and the queue; cfg_ready is always high
module header_line_unfolder #(
	parameter int LENGTH_BITS = hlu_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  hlu_pkg::in_word_t  item,
	output logic               empty,
	input  logic               pop,
	output hlu_pkg::out_word_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import hlu_pkg::*;

	logic   enq;
	entry_t enq_entry;
	logic   deq;
	logic   nonempty;
	entry_t head;

	// register write is a single flop, never stalls
	assign cfg_ready = 1'b1;

	// front: cr hold, fold wait, length count, result classification
	hlu_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.q_full    (full),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.enq       (enq),
		.enq_entry (enq_entry)
	);

	// short queue decoupling the byte side from the result side
	hlu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (enq),
		.enq_entry (enq_entry),
		.deq       (deq),
		.full      (full),
		.nonempty  (nonempty),
		.head      (head)
	);

	// back: walks the one or two words of the head entry
	hlu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.nonempty (nonempty),
		.pop      (pop),
		.deq      (deq),
		.empty    (empty),
		.result   (result)
	);

endmodule
